// File: hdl/abmrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abmrf_pkg;

  localparam int unsigned NUM_BANKS = 6;
  localparam int unsigned BANK_W    = $clog2(NUM_BANKS);
  localparam int unsigned FIQ_REGS  = 5;

  // Command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_SWITCH = 3'd2;
  localparam logic [2:0] CMD_IRQ    = 3'd3;
  localparam logic [2:0] CMD_TEST   = 3'd4;

  // Register index codes above the general registers
  localparam logic [4:0] IDX_CPSR = 5'd16;
  localparam logic [4:0] IDX_SPSR = 5'd17;

  // Mode codes
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Bank numbers
  localparam logic [BANK_W-1:0] BANK_USR = BANK_W'(0);
  localparam logic [BANK_W-1:0] BANK_FIQ = BANK_W'(1);
  localparam logic [BANK_W-1:0] BANK_SVC = BANK_W'(2);
  localparam logic [BANK_W-1:0] BANK_ABT = BANK_W'(3);
  localparam logic [BANK_W-1:0] BANK_IRQ = BANK_W'(4);
  localparam logic [BANK_W-1:0] BANK_UND = BANK_W'(5);

  // Status register bit positions
  localparam int unsigned PSR_N = 31;
  localparam int unsigned PSR_Z = 30;
  localparam int unsigned PSR_C = 29;
  localparam int unsigned PSR_V = 28;
  localparam int unsigned PSR_I = 7;
  localparam int unsigned PSR_F = 6;
  localparam int unsigned PSR_T = 5;

  localparam logic [31:0] PSR_RESET = {24'h0, 1'b1, 1'b1, 1'b0, MODE_SVC};

  localparam logic [31:0] IRQ_VECTOR = 32'h0000_0018;
  localparam logic [31:0] ARM_PIPE   = 32'd8;
  localparam logic [31:0] ARM_INSN   = 32'd4;

  // Condition codes
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [4:0]  target_mode;
    logic [3:0]  cond_code;
  } op_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        cond_pass;
    logic        irq_taken;
    logic [31:0] fetch_address;
    logic        bad_mode;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } bank_t;

  function automatic bank_t bank_of(input logic [4:0] mode);
    bank_t b;
    b.valid = 1'b1;
    case (mode)
      MODE_USR: b.bank = BANK_USR;
      MODE_SYS: b.bank = BANK_USR;
      MODE_FIQ: b.bank = BANK_FIQ;
      MODE_SVC: b.bank = BANK_SVC;
      MODE_ABT: b.bank = BANK_ABT;
      MODE_IRQ: b.bank = BANK_IRQ;
      MODE_UND: b.bank = BANK_UND;
      default: begin
        b.valid = 1'b0;
        b.bank  = BANK_USR;
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/abmrf_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface abmrf_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [4:0]  reg_index;
  logic [31:0] write_value;
  logic [4:0]  target_mode;
  logic [3:0]  cond_code;

  modport source (output valid, cmd, reg_index, write_value, target_mode, cond_code,
                  input ready);
  modport sink (input valid, cmd, reg_index, write_value, target_mode, cond_code,
                output ready);
endinterface

`default_nettype wire

// File: hdl/abmrf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface abmrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        cond_pass;
  logic        irq_taken;
  logic [31:0] fetch_address;
  logic        bad_mode;

  modport source (output valid, read_data, cond_pass, irq_taken, fetch_address, bad_mode,
                  input ready);
  modport sink (input valid, read_data, cond_pass, irq_taken, fetch_address, bad_mode,
                output ready);
endinterface

`default_nettype wire

// File: hdl/abmrf_cond.sv
`timescale 1ns / 1ps
`default_nettype none

module abmrf_cond
  import abmrf_pkg::*;
(
  input  wire logic [3:0]  cond_code_i,
  input  wire logic [31:0] psr_i,
  output logic             pass_o
);

  logic n, z, c, v;

  assign n = psr_i[PSR_N];
  assign z = psr_i[PSR_Z];
  assign c = psr_i[PSR_C];
  assign v = psr_i[PSR_V];

  always_comb begin
    case (cond_code_i)
      COND_EQ: pass_o = z;
      COND_NE: pass_o = !z;
      COND_CS: pass_o = c;
      COND_CC: pass_o = !c;
      COND_MI: pass_o = n;
      COND_PL: pass_o = !n;
      COND_VS: pass_o = v;
      COND_VC: pass_o = !v;
      COND_HI: pass_o = c && !z;
      COND_LS: pass_o = !c || z;
      COND_GE: pass_o = (n == v);
      COND_LT: pass_o = (n != v);
      COND_GT: pass_o = !z && (n == v);
      COND_LE: pass_o = z || (n != v);
      default: pass_o = 1'b1; // AL and NV
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/abmrf_state.sv
`timescale 1ns / 1ps
`default_nettype none

module abmrf_state
  import abmrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        exec_i,
  input  wire op_t         op_i,
  input  wire logic [31:0] exc_base_i,
  output res_t             res_o
);

  // Only the entries the banks really use are kept: r8-r12 for user and FIQ,
  // r13/r14 for every bank.
  logic [31:0] vis_q    [16];
  logic [31:0] vis_d    [16];
  logic [31:0] usr_hi_q [FIQ_REGS];
  logic [31:0] usr_hi_d [FIQ_REGS];
  logic [31:0] fiq_hi_q [FIQ_REGS];
  logic [31:0] fiq_hi_d [FIQ_REGS];
  logic [31:0] sp_q     [NUM_BANKS];
  logic [31:0] sp_d     [NUM_BANKS];
  logic [31:0] lr_q     [NUM_BANKS];
  logic [31:0] lr_d     [NUM_BANKS];
  logic [31:0] spsr_q   [NUM_BANKS];
  logic [31:0] spsr_d   [NUM_BANKS];
  logic [31:0] cpsr_q;
  logic [31:0] cpsr_d;

  bank_t             cur_b;
  bank_t             tgt_b;
  logic [BANK_W-1:0] ob;
  logic [BANK_W-1:0] nb;
  logic              sw_en;
  logic [4:0]        sw_mode;
  logic              irq_go;
  logic              pass;
  logic [31:0]       fetch;

  abmrf_cond u_cond (
    .cond_code_i (op_i.cond_code),
    .psr_i       (cpsr_q),
    .pass_o      (pass)
  );

  assign cur_b  = bank_of(cpsr_q[4:0]);
  assign ob     = cur_b.valid ? cur_b.bank : BANK_USR;
  assign tgt_b  = bank_of(op_i.target_mode);
  assign irq_go = (op_i.cmd == CMD_IRQ) && !cpsr_q[PSR_I];
  assign fetch  = exc_base_i + IRQ_VECTOR;

  always_comb begin
    sw_en   = 1'b0;
    sw_mode = op_i.target_mode;
    if (op_i.cmd == CMD_SWITCH && tgt_b.valid) begin
      sw_en = 1'b1;
    end else if (irq_go) begin
      sw_en   = 1'b1;
      sw_mode = MODE_IRQ;
    end
  end

  assign nb = (sw_mode == MODE_IRQ && irq_go) ? BANK_IRQ : tgt_b.bank;

  // Result
  always_comb begin
    res_o = '0;
    case (op_i.cmd)
      CMD_READ: begin
        if (!op_i.reg_index[4]) begin
          res_o.read_data = vis_q[op_i.reg_index[3:0]];
        end else if (op_i.reg_index == IDX_CPSR) begin
          res_o.read_data = cpsr_q;
        end else if (op_i.reg_index == IDX_SPSR) begin
          res_o.read_data = spsr_q[ob];
        end
      end
      CMD_SWITCH: res_o.bad_mode = !tgt_b.valid;
      CMD_IRQ: begin
        res_o.irq_taken     = irq_go;
        res_o.fetch_address = irq_go ? fetch : '0;
      end
      CMD_TEST: res_o.cond_pass = pass;
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    vis_d    = vis_q;
    usr_hi_d = usr_hi_q;
    fiq_hi_d = fiq_hi_q;
    sp_d     = sp_q;
    lr_d     = lr_q;
    spsr_d   = spsr_q;
    cpsr_d   = cpsr_q;

    if (op_i.cmd == CMD_WRITE) begin
      if (!op_i.reg_index[4]) begin
        vis_d[op_i.reg_index[3:0]] = op_i.write_value;
      end else if (op_i.reg_index == IDX_CPSR) begin
        cpsr_d = {op_i.write_value[31:5], cpsr_q[4:0]};
      end else if (op_i.reg_index == IDX_SPSR) begin
        spsr_d[ob] = op_i.write_value;
      end
    end

    if (sw_en) begin
      cpsr_d[4:0] = sw_mode;
      if (ob != nb) begin
        for (int k = 0; k < FIQ_REGS; k++) begin
          if (ob == BANK_FIQ) begin
            fiq_hi_d[k] = vis_q[8+k];
            vis_d[8+k]  = usr_hi_q[k];
          end else if (nb == BANK_FIQ) begin
            usr_hi_d[k] = vis_q[8+k];
            vis_d[8+k]  = fiq_hi_q[k];
          end
        end
        sp_d[ob]  = vis_q[13];
        lr_d[ob]  = vis_q[14];
        vis_d[13] = sp_q[nb];
        vis_d[14] = lr_q[nb];
      end
    end

    if (irq_go) begin
      spsr_d[BANK_IRQ] = cpsr_q;
      cpsr_d[PSR_I]    = 1'b1;
      cpsr_d[PSR_T]    = 1'b0;
      vis_d[14]        = cpsr_q[PSR_T] ? vis_q[15] : vis_q[15] - ARM_INSN;
      vis_d[15]        = fetch + ARM_PIPE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) vis_q[i] <= '0;
      for (int i = 0; i < FIQ_REGS; i++) begin
        usr_hi_q[i] <= '0;
        fiq_hi_q[i] <= '0;
      end
      for (int i = 0; i < NUM_BANKS; i++) begin
        sp_q[i]   <= '0;
        lr_q[i]   <= '0;
        spsr_q[i] <= '0;
      end
      cpsr_q <= PSR_RESET;
    end else if (exec_i) begin
      vis_q    <= vis_d;
      usr_hi_q <= usr_hi_d;
      fiq_hi_q <= fiq_hi_d;
      sp_q     <= sp_d;
      lr_q     <= lr_d;
      spsr_q   <= spsr_d;
      cpsr_q   <= cpsr_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/arm_banked_mode_register_file_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Banked ARM register file with mode switching, IRQ entry and condition test.
// Each command transaction on cmd_i yields exactly one response transaction on
// rsp_o. A command is captured in an input register, executed against the
// register file by one pass of combinational logic, and its response is held in
// an output register; one command is accepted every cycle while rsp_o is being
// drained. The register file state is updated at the same edge that loads the
// response, so each command sees the effects of all earlier ones. After reset
// the core is in supervisor mode with IRQ and FIQ masked and r15 at zero. The
// user must write exception_base through cfg_we_i/cfg_wdata_i only while the
// core is idle; the core does not enforce this. It does not move r15 by itself.

module arm_banked_mode_register_file_core
  import abmrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  abmrf_cmd_if.sink        cmd_i,
  abmrf_rsp_if.source      rsp_o
);

  logic        op_valid_q;
  op_t         op_q;
  logic        res_valid_q;
  res_t        res_q;
  res_t        res;
  logic        advance;
  logic [31:0] exc_base_q;

  assign advance     = op_valid_q && (!res_valid_q || rsp_o.ready);
  assign cmd_i.ready = !op_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_base_q <= '0;
    end else if (cfg_we_i) begin
      exc_base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      op_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      op_q.cmd         <= cmd_i.cmd;
      op_q.reg_index   <= cmd_i.reg_index;
      op_q.write_value <= cmd_i.write_value;
      op_q.target_mode <= cmd_i.target_mode;
      op_q.cond_code   <= cmd_i.cond_code;
    end
  end

  abmrf_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (advance),
    .op_i       (op_q),
    .exc_base_i (exc_base_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid         = res_valid_q;
  assign rsp_o.read_data     = res_q.read_data;
  assign rsp_o.cond_pass     = res_q.cond_pass;
  assign rsp_o.irq_taken     = res_q.irq_taken;
  assign rsp_o.fetch_address = res_q.fetch_address;
  assign rsp_o.bad_mode      = res_q.bad_mode;

endmodule

`default_nettype wire
